>>> rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion wrappers for the divisor-count search block.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check an implication or expression on every rising clock edge outside reset
`define MDC_ASSERT(lbl, clk, rst_n, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
		else $error("assertion failed");

// Check that a condition never holds outside reset
`define MDC_NEVER(lbl, clk, rst_n, cond) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
		else $error("forbidden condition seen");

`endif

>>> rtl/mdc_pkg.sv
// ----------------------------------------------------------------------------
// mdc_pkg
// Constants, types and elaboration-time prime table for the divisor search.
// ----------------------------------------------------------------------------
package mdc_pkg;

	localparam int PRIME_LIMIT_DEF = 256;
	localparam int SIEVE_MAX       = 256;
	localparam int ROM_DEPTH       = 54;
	localparam int IDX_W           = $clog2(ROM_DEPTH + 1);
	localparam int NUM_W           = 16;
	localparam int CNT_W           = 8;
	localparam int EXP_W           = 5;
	localparam int PRIME_W         = 8;
	localparam int SQ_W            = 2 * PRIME_W + 1;
	// Reciprocal ceil(2^24 / p) gives exact quotients for 16-bit dividends
	localparam int RECIP_SHIFT     = NUM_W + PRIME_W;
	localparam int RECIP_W         = RECIP_SHIFT;
	localparam int PROD_W          = NUM_W + RECIP_W;
	localparam int BACK_W          = NUM_W + PRIME_W;

	typedef logic [ROM_DEPTH-1:0][PRIME_W-1:0] prime_rom_t;

	// Request into the shared divide unit
	typedef struct packed {
		logic [NUM_W-1:0] rest;
		logic [IDX_W-1:0] idx;
	} mdc_div_req_t;

	// Answer of the shared divide unit
	typedef struct packed {
		logic             exhausted;
		logic             divisible;
		logic [NUM_W-1:0] quotient;
	} mdc_div_res_t;

	// Sieve the primes 2..limit into an ascending table, unused entries zero
	function automatic prime_rom_t build_primes(input int limit);
		prime_rom_t rom;
		bit         composite [0:SIEVE_MAX];
		int         lim;
		int         cnt;
		rom = '0;
		cnt = 0;
		lim = (limit > SIEVE_MAX) ? SIEVE_MAX : ((limit < 0) ? 0 : limit);
		for (int i = 0; i <= SIEVE_MAX; i++) begin
			composite[i] = 1'b0;
		end
		for (int i = 2; i <= lim; i++) begin
			if (!composite[i]) begin
				for (int j = i + i; j <= lim; j += i) begin
					composite[j] = 1'b1;
				end
				if (cnt < ROM_DEPTH) begin
					rom[cnt] = PRIME_W'(i);
					cnt++;
				end
			end
		end
		return rom;
	endfunction

	// Number of filled table entries
	function automatic int count_primes(input prime_rom_t rom);
		int cnt;
		cnt = 0;
		for (int i = 0; i < ROM_DEPTH; i++) begin
			if (rom[i] != '0) begin
				cnt++;
			end
		end
		return cnt;
	endfunction

endpackage

>>> rtl/max_divisor_count_in_range_unit.sv
// ----------------------------------------------------------------------------
// max_divisor_count_in_range_unit
// Finds the first number of an inclusive range with the most divisors.
// ----------------------------------------------------------------------------
//  Channel  Dir  Fields (lowest bit first)             Transaction
//  s_*      in   range_low[15:0], range_high[31:16]    s_tvalid & s_tready
//  m_*      out  best_number[15:0], divisor_count[23:16] m_tvalid & m_tready
//
//  Per number: a probe and a check per prime tried, a wait and a check
//  per prime factor (with multiplicity), then a closing probe and a
//  finish; primes are tried up to the first with p*p above the remainder
//  or the table end. A request adds an accept step and a result step,
//  which waits for a free output register, to the work over its range;
//  the shared divide unit has one reciprocal multiply, one check multiply.
//  s_tready is high only between requests; a result waits in the output
//  register and a new request is taken meanwhile. No clearing pass at reset.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module max_divisor_count_in_range_unit
	import mdc_pkg::*;
#(
	parameter int PRIME_LIMIT = PRIME_LIMIT_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [31:0] s_tdata,   // range_low[15:0], range_high[31:16]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [23:0] m_tdata    // best_number[15:0], divisor_count[23:16]
);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_PRIME,
		ST_WAIT,
		ST_CHK,
		ST_FIN,
		ST_DONE
	} state_t;

	state_t             state_q;
	logic               m_tvalid_q;
	logic [NUM_W-1:0]   out_num_q;
	logic [CNT_W-1:0]   out_cnt_q;
	logic [NUM_W-1:0]   high_q;
	logic [NUM_W-1:0]   n_q;
	logic [NUM_W-1:0]   rest_q;
	logic [CNT_W-1:0]   total_q;
	logic [EXP_W-1:0]   e_q;
	logic [IDX_W-1:0]   k_q;
	logic [NUM_W-1:0]   best_num_q;
	logic [CNT_W-1:0]   best_cnt_q;

	logic [NUM_W-1:0]   in_low;
	logic [NUM_W-1:0]   in_high;
	logic               in_fire;
	logic               out_free;
	logic [CNT_W+EXP_W-1:0] tot_mul;
	logic [CNT_W-1:0]   cnt_fin;
	mdc_div_req_t       div_req;
	mdc_div_res_t       div_res;

	assign in_low   = s_tdata[15:0];
	assign in_high  = s_tdata[31:16];
	assign s_tready = (state_q == ST_IDLE);
	assign in_fire  = s_tvalid && s_tready;
	assign out_free = !m_tvalid_q || m_tready;

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {out_cnt_q, out_num_q};

	// Shared trial-division unit
	assign div_req.rest = rest_q;
	assign div_req.idx  = k_q;

	mdc_div #(
		.PRIME_LIMIT(PRIME_LIMIT)
	) u_div (
		.clk(clk),
		.req(div_req),
		.res(div_res)
	);

	// Fold exponent into the divisor count; double for a prime leftover
	assign tot_mul = (CNT_W+EXP_W)'(total_q) * (CNT_W+EXP_W)'(e_q);
	assign cnt_fin = (rest_q > NUM_W'(1)) ? {total_q[CNT_W-2:0], 1'b0} : total_q;

	// Sequencer, datapath and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			m_tvalid_q <= 1'b0;
			out_num_q  <= '0;
			out_cnt_q  <= '0;
			high_q     <= '0;
			n_q        <= '0;
			rest_q     <= '0;
			total_q    <= '0;
			e_q        <= '0;
			k_q        <= '0;
			best_num_q <= '0;
			best_cnt_q <= '0;
		end else begin
			// drop the result once taken; a finished search reloads it below
			if (m_tvalid_q && m_tready && (state_q != ST_DONE)) begin
				m_tvalid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (in_fire) begin
						best_num_q <= '0;
						best_cnt_q <= '0;
						high_q     <= in_high;
						n_q        <= in_low;
						rest_q     <= in_low;
						total_q    <= CNT_W'(1);
						e_q        <= EXP_W'(1);
						k_q        <= '0;
						state_q    <= (in_low > in_high) ? ST_DONE : ST_PRIME;
					end
				end
				ST_PRIME: begin
					// divide unit loads this prime now
					state_q <= div_res.exhausted ? ST_FIN : ST_CHK;
				end
				ST_WAIT: begin
					state_q <= ST_CHK;
				end
				ST_CHK: begin
					if (div_res.divisible) begin
						rest_q  <= div_res.quotient;
						e_q     <= e_q + EXP_W'(1);
						state_q <= ST_WAIT;
					end else begin
						total_q <= tot_mul[CNT_W-1:0];
						e_q     <= EXP_W'(1);
						k_q     <= k_q + IDX_W'(1);
						state_q <= ST_PRIME;
					end
				end
				ST_FIN: begin
					// zero is skipped; ties keep the earlier number
					if ((n_q != '0) && (cnt_fin > best_cnt_q)) begin
						best_cnt_q <= cnt_fin;
						best_num_q <= n_q;
					end
					if (n_q == high_q) begin
						state_q <= ST_DONE;
					end else begin
						n_q     <= n_q + NUM_W'(1);
						rest_q  <= n_q + NUM_W'(1);
						total_q <= CNT_W'(1);
						e_q     <= EXP_W'(1);
						k_q     <= '0;
						state_q <= ST_PRIME;
					end
				end
				ST_DONE: begin
					if (out_free) begin
						out_num_q  <= best_num_q;
						out_cnt_q  <= best_cnt_q;
						m_tvalid_q <= 1'b1;
						state_q    <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Empty range goes straight to the result
	`MDC_ASSERT(a_empty_done, clk, arst_n, (in_fire && (in_low > in_high)) |=> (state_q == ST_DONE))
	// A finished search with a free output slot presents its result next cycle
	`MDC_ASSERT(a_done_out, clk, arst_n, (state_q == ST_DONE && out_free) |=> m_tvalid)
	// Each division by a found factor shrinks the remainder
	`MDC_ASSERT(a_rest_drop, clk, arst_n, (state_q == ST_CHK && div_res.divisible) |=> (rest_q < $past(rest_q)))
	// No 16-bit number has more than 128 divisors
	`MDC_NEVER(a_cnt_range, clk, arst_n, best_cnt_q > CNT_W'(128))

endmodule

>>> rtl/mdc_div.sv
// ----------------------------------------------------------------------------
// mdc_div
// Shared trial-division unit: divides a 16-bit remainder by a table prime
// through a reciprocal multiply, then checks the quotient by a back multiply.
// ----------------------------------------------------------------------------
module mdc_div
	import mdc_pkg::*;
#(
	parameter int PRIME_LIMIT = PRIME_LIMIT_DEF
) (
	input  logic         clk,
	input  mdc_div_req_t req,
	output mdc_div_res_t res
);

	localparam prime_rom_t       PRIMES   = build_primes(PRIME_LIMIT);
	localparam int               PCOUNT   = count_primes(PRIMES);
	localparam logic [IDX_W-1:0] PCOUNT_L = IDX_W'(PCOUNT);

	logic [PRIME_W-1:0] prime_tab [ROM_DEPTH];
	logic [RECIP_W-1:0] recip_tab [ROM_DEPTH];
	logic [SQ_W-1:0]    psq_tab   [ROM_DEPTH];

	logic [PROD_W-1:0]  prod;
	logic [NUM_W-1:0]   q_s1;
	logic [NUM_W-1:0]   rest_s1;
	logic [PRIME_W-1:0] p_s1;
	logic [BACK_W-1:0]  back;

	// Build prime, reciprocal and square tables at elaboration
	for (genvar g = 0; g < ROM_DEPTH; g++) begin : g_tab
		localparam int P  = int'(PRIMES[g]);
		localparam int PD = (P < 2) ? 1 : P;
		localparam int RC = ((1 << RECIP_SHIFT) + PD - 1) / PD;
		assign prime_tab[g] = PRIMES[g];
		assign recip_tab[g] = RECIP_W'(RC);
		assign psq_tab[g]   = SQ_W'(P * P);
	end

	// Stop the prime walk at the table end or once p*p exceeds the remainder
	assign res.exhausted = (req.idx == PCOUNT_L) ||
		(psq_tab[req.idx[IDX_W-1:0]] > {1'b0, req.rest});

	// Quotient estimate by reciprocal multiply
	assign prod = PROD_W'(req.rest) * PROD_W'(recip_tab[req.idx]);

	always_ff @(posedge clk) begin
		q_s1    <= prod[PROD_W-1:RECIP_SHIFT];
		rest_s1 <= req.rest;
		p_s1    <= prime_tab[req.idx];
	end

	// Check exactness: the prime divides when quotient * p returns the remainder
	assign back          = BACK_W'(q_s1) * BACK_W'(p_s1);
	assign res.divisible = (back == BACK_W'(rest_s1));
	assign res.quotient  = q_s1;

endmodule

>>> test/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for max_divisor_count_in_range_unit: drives range
// requests over the input stream and predicts, by trial division with its own
// table of small primes, the first number with the most divisors. Each
// result is compared field by field with the oldest pending prediction.
// ----------------------------------------------------------------------------
module tb;
	timeunit 1ns;
	timeprecision 1ps;
	import mdc_pkg::*;

	// Request fields, lowest first: range_low, range_high
	typedef struct packed {
		logic [NUM_W-1:0] range_high;
		logic [NUM_W-1:0] range_low;
	} range_req_t;

	// Result fields, lowest first: best_number, divisor_count
	typedef struct packed {
		logic [CNT_W-1:0] divisor_count;
		logic [NUM_W-1:0] best_number;
	} best_answer_t;

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [31:0] s_tdata;   // range_low[15:0], range_high[31:16]
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [23:0] m_tdata;   // best_number[15:0], divisor_count[23:16]

	best_answer_t expected_answers [$];
	int unsigned  trial_primes [$];
	int           error_count;
	int           requests_sent;
	int           answers_checked;
	longint       numbers_scanned;
	int           top_count_seen;
	int           burst_left;
	int           stall_mode = 0;
	int           stall_left = 0;

	max_divisor_count_in_range_unit dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	// Clock: 8 ns period
	initial begin
		clk = 1'b0;
	end
	always #4 clk = ~clk;

	// Print one error line and count it
	task automatic report_error(input string msg);
		error_count++;
		$display("[%0t] ERROR: %s", $realtime, msg);
	endtask

	// Build the prime table up to 256 by testing each candidate against smaller primes
	function automatic void load_trial_primes();
		bit is_prime;
		trial_primes.delete();
		for (int unsigned n = 2; n <= 256; n++) begin
			is_prime = 1'b1;
			foreach (trial_primes[k]) begin
				if (n % trial_primes[k] == 0) begin
					is_prime = 1'b0;
				end
			end
			if (is_prime && trial_primes.size() < ROM_DEPTH) begin
				trial_primes.push_back(n);
			end
		end
	endfunction

	// Divisor count from the prime exponents; a leftover above 1 is one more prime
	function automatic int unsigned divisor_total(input int unsigned value);
		int unsigned rest;
		int unsigned total;
		int unsigned power;
		rest = value;
		total = 1;
		foreach (trial_primes[k]) begin
			power = 1;
			while (rest % trial_primes[k] == 0) begin
				rest = rest / trial_primes[k];
				power++;
			end
			total = total * power;
		end
		if (rest > 1) begin
			total = total * 2;
		end
		return total;
	endfunction

	// First number of the range with the strictly largest divisor count; zero is skipped
	function automatic best_answer_t predict_most_divisors(input range_req_t req);
		best_answer_t ans;
		int unsigned  best_num;
		int unsigned  best_cnt;
		int unsigned  cnt;
		best_num = 0;
		best_cnt = 0;
		for (int unsigned n = req.range_low; n <= req.range_high; n++) begin
			if (n != 0) begin
				cnt = divisor_total(n);
				if (cnt > best_cnt) begin
					best_cnt = cnt;
					best_num = n;
				end
			end
		end
		if (best_cnt > 255) begin
			best_cnt = 255;
		end
		ans.best_number = best_num[NUM_W-1:0];
		ans.divisor_count = best_cnt[CNT_W-1:0];
		return ans;
	endfunction

	// Drop valid and hold the sender idle for some cycles
	task automatic idle_sender(input int cycles);
		s_tvalid <= 1'b0;
		repeat (cycles) @(posedge clk);
	endtask

	// Send one range request in bursts; record its prediction once accepted
	task automatic send_range(input int unsigned lo, input int unsigned hi);
		range_req_t   req;
		best_answer_t ans;
		req.range_low = lo[NUM_W-1:0];
		req.range_high = hi[NUM_W-1:0];
		if (burst_left == 0) begin
			idle_sender($urandom_range(1, 12));
			burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(10, 20)
				: $urandom_range(1, 4);
		end
		burst_left--;
		s_tvalid <= 1'b1;
		s_tdata <= req;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		ans = predict_most_divisors(req);
		expected_answers.push_back(ans);
		requests_sent++;
		if (req.range_high >= req.range_low) begin
			numbers_scanned += req.range_high - req.range_low + 1;
		end
		if (ans.divisor_count > top_count_seen) begin
			top_count_seen = ans.divisor_count;
		end
	endtask

	// Hold the sender until every pending result has come back
	task automatic drain_results();
		idle_sender(1);
		while (expected_answers.size() != 0) @(posedge clk);
	endtask

	// Receive side: check each transaction, then stall on a pattern of its own
	always @(posedge clk) begin
		best_answer_t got;
		best_answer_t want;
		got = m_tdata;
		if (arst_n && m_tvalid && m_tready) begin
			if (expected_answers.size() == 0) begin
				report_error($sformatf("unexpected result best_number=%0d divisor_count=%0d",
					got.best_number, got.divisor_count));
			end else begin
				want = expected_answers.pop_front();
				answers_checked++;
				if (got.best_number !== want.best_number) begin
					report_error($sformatf("best_number got %0d want %0d",
						got.best_number, want.best_number));
				end
				if (got.divisor_count !== want.divisor_count) begin
					report_error($sformatf("divisor_count got %0d want %0d (best_number %0d)",
						got.divisor_count, want.divisor_count, want.best_number));
				end
			end
		end
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else begin
			if (stall_left == 0) begin
				stall_mode = $urandom_range(0, 2);
				stall_left = (stall_mode == 2) ? $urandom_range(1, 10) : $urandom_range(5, 60);
			end
			stall_left--;
			case (stall_mode)
				0: m_tready <= 1'b1;
				1: m_tready <= $urandom_range(0, 1);
				default: m_tready <= 1'b0;
			endcase
		end
	end

	// Single numbers at the field extremes, zero, and empty ranges
	task automatic test_edge_ranges();
		send_range(1, 1);
		send_range(65535, 65535);
		send_range(65521, 65521);
		send_range(0, 0);
		send_range(0, 1);
		send_range(10, 5);
		send_range(65535, 0);
		send_range(32768, 32768);
		send_range(63001, 63001);
	endtask

	// Ties between neighbours, where the smaller number must win, and one range without a tie
	task automatic test_ties();
		send_range(2, 3);
		send_range(14, 15);
		send_range(21, 22);
		send_range(10, 11);
	endtask

	// Ranges around highly composite numbers, the top of the field, and a wider scan from the bottom
	task automatic test_highly_composite();
		send_range(55430, 55450);
		send_range(45350, 45370);
		send_range(65500, 65535);
		send_range(1, 1000);
	endtask

	// Send with the pipeline fully drained before each request
	task automatic test_drained_requests();
		int unsigned lo;
		int unsigned hi;
		for (int i = 0; i < 4; i++) begin
			drain_results();
			lo = $urandom_range(0, 65535);
			hi = lo + $urandom_range(0, 255);
			send_range(lo, (hi > 65535) ? 65535 : hi);
		end
	endtask

	// Random ranges: mostly short, some wider, a few empty or starting at zero
	task automatic test_random_ranges(input int count);
		int unsigned lo;
		int unsigned span;
		int unsigned pick;
		for (int i = 0; i < count; i++) begin
			pick = $urandom_range(0, 99);
			lo = (pick < 3) ? 0 : $urandom_range(0, 65535);
			if (pick >= 95) begin
				send_range(lo, (lo == 0) ? 0 : $urandom_range(0, lo - 1));
			end else begin
				span = (pick >= 85) ? $urandom_range(32, 255) : $urandom_range(0, 31);
				send_range(lo, (lo + span > 65535) ? 65535 : lo + span);
			end
		end
	endtask

	// Main sequence
	initial begin
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		error_count = 0;
		requests_sent = 0;
		answers_checked = 0;
		numbers_scanned = 0;
		top_count_seen = 0;
		burst_left = 0;
		load_trial_primes();
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_edge_ranges();
		test_ties();
		test_highly_composite();
		test_drained_requests();
		test_random_ranges(80);

		// Wait for the last results, then let the block settle
		drain_results();
		repeat (200) @(posedge clk);
		if (expected_answers.size() != 0) begin
			report_error($sformatf("%0d results never arrived", expected_answers.size()));
		end
		$display("Run covered %0d range requests, %0d numbers scanned, %0d results checked.",
			requests_sent, numbers_scanned, answers_checked);
		$display("Largest divisor count seen: %0d; errors: %0d.", top_count_seen, error_count);
		if (error_count == 0) begin
			$display("** max_divisor_count_in_range_unit: PASSED **");
		end else begin
			$display("** max_divisor_count_in_range_unit: FAILED **");
		end
		$finish;
	end

	// Watchdog: far beyond the slowest correct run
	initial begin
		#100ms;
		$display("[%0t] ERROR: timeout", $realtime);
		$display("** max_divisor_count_in_range_unit: FAILED **");
		$finish;
	end

endmodule
